### rtl/gsp_pkg.sv
// gsp_pkg: shared types and constants for the shortest-path graph block.
// Used by gsp_ctrl, gsp_dp and weighted_graph_shortest_paths.
`default_nettype none
package gsp_pkg;

  localparam int NV_DEFAULT = 16;
  localparam int MAX_OUT    = 16;
  localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
  localparam logic [4:0]  PRED_NONE = 5'h1F;
  localparam logic [4:0]  VCOUNT_RESET = 5'd16;
  localparam logic [6:0]  EDGE_LIMIT = 7'd120;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_PATHS  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_WR2, S_RESP,
    S_INIT, S_SCAN, S_RELAX, S_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic set_err;
    logic check;
    logic wr2;
    logic resp;
    logic init;
    logic scan;
    logic relax;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bad;
    op_t  op;
    logic do_wr2;
    logic scan_done;
    logic found;
    logic relax_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/gsp_ctrl.sv
// gsp_ctrl: sequencer for matrix clear, edge operations and the path search.
// Depends on gsp_pkg; drives gsp_dp through cmd_t and reads sts_t.
`default_nettype none
module gsp_ctrl
  import gsp_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic s_tvalid,
  output logic       s_tready,
  output cmd_t       cmd,
  input  wire  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.bad) begin
          cmd.set_err = 1'b1;
          state_next  = S_RESP;
        end else if (sts.op == OP_PATHS) begin
          state_next = S_INIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.do_wr2 ? S_WR2 : S_RESP;
      end
      S_WR2: begin
        cmd.wr2    = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (sts.out_free) state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = sts.found ? S_RELAX : S_EMIT;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        if (sts.relax_last) state_next = S_SCAN;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free && sts.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

### rtl/gsp_dp.sv
// gsp_dp: adjacency memory, distance and predecessor tables, output register.
// Depends on gsp_pkg; commanded by gsp_ctrl.
`default_nettype none
module gsp_dp
  import gsp_pkg::*;
#(
  parameter int NUM_VERTICES = NV_DEFAULT
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_we,
  input  wire  logic [4:0]  cfg_wdata,
  input  wire  logic [23:0] s_tdata,
  input  wire  logic [1:0]  s_tuser,
  input  wire  cmd_t        cmd,
  output sts_t              sts,
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [63:0]       m_tdata,
  output logic              m_tlast
);

  localparam int CELLS = NUM_VERTICES * NUM_VERTICES;
  localparam int AW    = $clog2(CELLS);
  localparam int CAP   = (NUM_VERTICES < MAX_OUT) ? NUM_VERTICES : MAX_OUT;

  function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
    cell_addr = AW'(int'(r) * NUM_VERTICES + int'(c));
  endfunction

  // adjacency memory, one write and one registered read per cycle
  logic [15:0]   adj [CELLS];
  logic [AW-1:0] raddr, waddr;
  logic [15:0]   wdata, rdata;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) adj[waddr] <= wdata;
    rdata <= adj[raddr];
  end

  logic [4:0]    vcount, n_r;
  op_t           op;
  logic [3:0]    a_r, b_r;
  logic [15:0]   w_r;
  logic [6:0]    edges;
  logic [AW-1:0] clr;
  logic [4:0]    idx;
  logic          found;
  logic [3:0]    u;
  logic [23:0]   best, du;
  logic [15:0]   reached, visited;
  logic          rv;
  logic [3:0]    ri;
  logic [23:0]   dist_tbl [MAX_OUT];
  logic [4:0]    pred [MAX_OUT];
  logic [1:0]    rsp_status;
  logic [15:0]   rsp_weight;
  logic          out_free;

  logic [4:0]  n_eff;
  logic        va, vb, exist, do_wr2, bad, elig, rlx_upd, load_out;
  logic [3:0]  tix;
  logic [23:0] dsel, cand;
  logic [4:0]  psel;
  logic [24:0] sum;

  assign n_eff  = (vcount > 5'(CAP)) ? 5'(CAP) : vcount;
  assign va     = {1'b0, a_r} < n_r;
  assign vb     = {1'b0, b_r} < n_r;
  assign exist  = rdata != 16'd0;
  assign do_wr2 = (op == OP_INSERT && !exist) || (op == OP_REMOVE && exist);
  assign bad    = (op == OP_PATHS) ? !va
                : (!va || !vb || (op == OP_INSERT && (a_r == b_r || w_r == 16'd0)));

  assign tix  = rv ? ri : idx[3:0];
  assign dsel = dist_tbl[tix];
  assign psel = pred[tix];
  assign elig = (idx < n_r) && reached[idx[3:0]] && !visited[idx[3:0]];

  assign sum     = {1'b0, du} + {9'd0, rdata};
  assign cand    = sum[24] ? DIST_MAX : sum[23:0];
  assign rlx_upd = rv && !visited[ri] && exist && (!reached[ri] || cand < dsel);

  assign out_free = !m_tvalid || m_tready;
  assign load_out = (cmd.resp || cmd.emit) && out_free;

  always_comb begin
    raddr = cmd.relax ? cell_addr(u, idx[3:0]) : cell_addr(a_r, b_r);
    we    = 1'b0;
    waddr = cell_addr(a_r, b_r);
    wdata = (op == OP_INSERT) ? w_r : 16'd0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr;
      wdata = 16'd0;
    end else if (cmd.check && do_wr2) begin
      we = 1'b1;
    end else if (cmd.wr2) begin
      we    = 1'b1;
      waddr = cell_addr(b_r, a_r);
    end
  end

  always_comb begin
    sts            = '0;
    sts.clear_done = clr == AW'(CELLS - 1);
    sts.bad        = bad;
    sts.op         = op;
    sts.do_wr2     = do_wr2;
    sts.scan_done  = idx >= n_r;
    sts.found      = found;
    sts.relax_last = (idx >= n_r) && rv;
    sts.emit_last  = idx == (n_r - 5'd1);
    sts.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= VCOUNT_RESET;
      edges    <= '0;
      clr      <= '0;
      idx      <= '0;
      found    <= 1'b0;
      reached  <= '0;
      visited  <= '0;
      rv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      if (cmd.clear) clr <= clr + AW'(1);
      rv <= cmd.relax && (idx < n_r);
      if (cmd.check) begin
        if (op == OP_INSERT && !exist) edges <= edges + 7'd1;
        if (op == OP_REMOVE && exist)  edges <= edges - 7'd1;
      end
      if (cmd.init) begin
        reached <= 16'(1) << a_r;
        visited <= '0;
        idx     <= '0;
        found   <= 1'b0;
      end
      if (cmd.scan) begin
        if (idx < n_r) begin
          if (elig && (!found || dsel < best)) found <= 1'b1;
          idx <= idx + 5'd1;
        end else begin
          if (found) visited[u] <= 1'b1;
          idx   <= '0;
          found <= 1'b0;
        end
      end
      if (cmd.relax) begin
        idx <= (idx < n_r) ? idx + 5'd1 : 5'd0;
      end
      if (rlx_upd) reached[ri] <= 1'b1;
      if (cmd.emit && out_free) idx <= idx + 5'd1;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= op_t'(s_tuser);
      a_r <= s_tdata[3:0];
      b_r <= s_tdata[7:4];
      w_r <= s_tdata[23:8];
      n_r <= n_eff;
    end
    if (cmd.set_err) begin
      rsp_status <= ST_INVALID;
      rsp_weight <= '0;
    end
    if (cmd.check) begin
      unique case (op)
        OP_INSERT: rsp_status <= exist ? ST_CONFLICT : ST_OK;
        OP_REMOVE: rsp_status <= exist ? ST_OK : ST_CONFLICT;
        default:   rsp_status <= ST_OK;
      endcase
      rsp_weight <= (op == OP_QUERY) ? rdata : 16'd0;
    end
    if (cmd.init) begin
      dist_tbl[a_r] <= '0;
      pred[a_r]     <= PRED_NONE;
    end
    if (cmd.scan) begin
      if (idx < n_r) begin
        if (elig && (!found || dsel < best)) begin
          best <= dsel;
          u    <= idx[3:0];
        end
      end else begin
        du <= best;
      end
    end
    if (cmd.relax) ri <= idx[3:0];
    if (rlx_upd) begin
      dist_tbl[ri] <= cand;
      pred[ri]     <= {1'b0, u};
    end
    if (load_out) begin
      if (cmd.emit) begin
        m_tdata <= {5'd0, edges, reached[idx[3:0]],
                    reached[idx[3:0]] ? psel : PRED_NONE,
                    reached[idx[3:0]] ? dsel : DIST_MAX,
                    idx[3:0], 16'd0, ST_OK};
        m_tlast <= idx == (n_r - 5'd1);
      end else begin
        m_tdata <= {5'd0, edges, 1'b0, PRED_NONE, 24'd0, 4'd0, rsp_weight, rsp_status};
        m_tlast <= 1'b1;
      end
    end
  end

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    found |-> (reached[u] && !visited[u]))
    else $error("chosen vertex is not a reached, unsettled vertex");

  a_visited_reached: assert property (@(posedge clk) disable iff (rst)
    (visited & ~reached) == 16'd0)
    else $error("settled vertex was never reached");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edges <= EDGE_LIMIT)
    else $error("edge count beyond a full graph");

  a_relax_index: assert property (@(posedge clk) disable iff (rst)
    rv |-> ({1'b0, ri} < n_r))
    else $error("relaxation on a vertex outside the active range");

endmodule
`default_nettype wire

### rtl/weighted_graph_shortest_paths.sv
// weighted_graph_shortest_paths: top level of the graph store and path search.
// Depends on gsp_pkg, gsp_ctrl and gsp_dp.
//
//  channel   | dir | signals                          | contents, low bit first
//  ----------+-----+----------------------------------+------------------------------------
//  input     | in  | s_tvalid s_tready s_tdata s_tuser| tuser: opcode; tdata: a, b, weight
//  output    | out | m_tvalid m_tready m_tdata m_tlast| status, edge_weight, vertex_id,
//            |     |                                  | distance, pred, reachable, edge_total
//  config    | in  | cfg_we cfg_wdata                 | vertex_count
//
// After reset the matrix is swept to zero, one cell a cycle over all NUM_VERTICES squared
// cells, while s_tready stays low; config writes are taken throughout.
// A successful insert or remove passes through DISPATCH, READ, CHECK, WR2 and RESP; a query
// and a refused insert or remove skip WR2, and an invalid operand goes from DISPATCH to RESP.
// A shortest-path run of n vertices is a series of settles: each settle is a linear minimum
// scan over the table followed by one pipelined pass over a matrix row through the single
// memory read port; a last empty scan and the emit of n results close the run.
// One item is in work at a time; the next is accepted once its last result sits in
// the output register, and an output stall holds the emit sequence.
`default_nettype none
module weighted_graph_shortest_paths
  import gsp_pkg::*;
#(
  parameter int NUM_VERTICES = NV_DEFAULT
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_we,
  input  wire  logic [4:0]  cfg_wdata,  // vertex_count
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [23:0] s_tdata,    // vertex_a[3:0], vertex_b[7:4], weight[23:8]
  input  wire  logic [1:0]  s_tuser,    // opcode[1:0]
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [63:0]       m_tdata,    // status[1:0], edge_weight[17:2], vertex_id[21:18],
                                        // distance[45:22], pred_vertex[50:46],
                                        // reachable[51], edge_total[58:52]
  output logic              m_tlast     // last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the state, issues one command group per cycle
  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: matrix memory, tables, counters and the output register
  gsp_dp #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
